// ===== sv/dcg_pkg.sv =====
package dcg_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_MAX_MOTOR      = 3'd0;
	localparam logic [2:0] REG_MIN_MOTOR      = 3'd1;
	localparam logic [2:0] REG_MAX_DRIVE      = 3'd2;
	localparam logic [2:0] REG_MIN_DRIVE      = 3'd3;
	localparam logic [2:0] REG_OBSTACLE_LEVEL = 3'd4;
	localparam logic [2:0] REG_CLEAR_LEVEL    = 3'd5;
	localparam logic [2:0] REG_RANGE_ONLY     = 3'd6;
	localparam logic [2:0] REG_COUNT_REVERSE  = 3'd7;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	// delta magnitude (max 2^15) times one million fits in 35 bits
	localparam int DELTA_W      = 16;
	localparam int SCALE_W      = 20;
	localparam int DIVIDEND_W   = 35;
	localparam int DIVISOR_W    = 32;
	localparam int SPEED_W      = 36;
	localparam int STEP_CNT_W   = 6;
	localparam logic [SCALE_W-1:0]    US_PER_SECOND = 20'd1000000;
	localparam logic [STEP_CNT_W-1:0] DIV_STEPS     = 6'd35;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== sv/dcg_tick_if.sv =====
interface dcg_tick_if import dcg_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] timestamp;
	logic [31:0] elapsed_us;
	logic [7:0]  motor_cmd;
	logic [7:0]  drive_cmd;
	logic [15:0] encoder_count;
	logic [11:0] stop_sample_a;
	logic [11:0] stop_sample_b;

	modport source (
		output valid, timestamp, elapsed_us, motor_cmd, drive_cmd,
		       encoder_count, stop_sample_a, stop_sample_b,
		input  ready
	);
	modport sink (
		input  valid, timestamp, elapsed_us, motor_cmd, drive_cmd,
		       encoder_count, stop_sample_a, stop_sample_b,
		output ready
	);
endinterface

// ===== sv/dcg_report_if.sv =====
interface dcg_report_if import dcg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [31:0]               packet_number;
	logic [31:0]               timestamp_echo;
	logic [7:0]                motor_echo;
	logic [7:0]                drive_echo;
	logic [31:0]               position;
	logic signed [SPEED_W-1:0] speed;
	logic [7:0]                pwm_motor;
	logic [7:0]                pwm_drive;

	modport source (
		output valid, packet_number, timestamp_echo, motor_echo, drive_echo,
		       position, speed, pwm_motor, pwm_drive,
		input  ready
	);
	modport sink (
		input  valid, packet_number, timestamp_echo, motor_echo, drive_echo,
		       position, speed, pwm_motor, pwm_drive,
		output ready
	);
endinterface

// ===== sv/dcg_div.sv =====
module dcg_div import dcg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_ctl_t              ctl,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output div_sts_t              sts,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic [STEP_CNT_W-1:0] cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= DIV_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign sts.busy = cnt_q != '0;
	assign sts.done = cnt_q == STEP_CNT_W'(1);
	assign quotient = quo_q;

endmodule

// ===== sv/drive_command_gate_obstacle_stop.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+-----------------------------------------------------------
// tick     | in  | timestamp, elapsed_us, motor/drive cmd, encoder, 2 samples
// report   | out | packet number, echoes, position, speed, latched PWM values
// cfg      | in  | write enable, register index, 12-bit data (no read-back)
//
// A tick beat passes through idle/accept, multiply, divider load, 35 divider steps
// and finish when elapsed_us is nonzero, and through idle/accept, multiply and finish
// when it is zero; the divider is a restoring one. tick.ready is high only while idle.
// Command gating, obstacle flags, unwrapping and counters update at acceptance.
// The report register holds a beat until taken; a full register stalls finish.
// arst_n clears configuration to its defaults and all control state at once.
module drive_command_gate_obstacle_stop import dcg_pkg::*; #(
	parameter int NUM_STOPS = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	dcg_tick_if.sink               tick,
	dcg_report_if.source           report
);

	// ---------------- configuration registers ----------------
	logic [7:0]  max_motor_q, min_motor_q, max_drive_q, min_drive_q;
	logic [11:0] obstacle_level_q, clear_level_q;
	logic        range_only_q, count_reverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_motor_q      <= 8'd20;
			min_motor_q      <= 8'd10;
			max_drive_q      <= 8'd17;
			min_drive_q      <= 8'd7;
			obstacle_level_q <= 12'd2000;
			clear_level_q    <= 12'd5;
			range_only_q     <= 1'b0;
			count_reverse_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_MOTOR:      max_motor_q      <= cfg_data[7:0];
				REG_MIN_MOTOR:      min_motor_q      <= cfg_data[7:0];
				REG_MAX_DRIVE:      max_drive_q      <= cfg_data[7:0];
				REG_MIN_DRIVE:      min_drive_q      <= cfg_data[7:0];
				REG_OBSTACLE_LEVEL: obstacle_level_q <= cfg_data;
				REG_CLEAR_LEVEL:    clear_level_q    <= cfg_data;
				REG_RANGE_ONLY:     range_only_q     <= cfg_data[0];
				REG_COUNT_REVERSE:  count_reverse_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	state_t state_q, state_d;
	logic   tick_fire;
	logic   load_out;
	logic   out_valid_q;
	logic   zero_elapsed_q;
	div_ctl_t div_ctl;
	div_sts_t div_sts;

	assign tick_fire = tick.valid && tick.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (tick_fire) state_d = ST_MUL;
			ST_MUL:  state_d = zero_elapsed_q ? ST_FIN : ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (div_sts.done) state_d = ST_FIN;
			ST_FIN:  if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tick.ready    = 1'b0;
		div_ctl.start = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: tick.ready    = 1'b1;
			ST_LOAD: div_ctl.start = 1'b1;
			// finish only once the report register is free or being emptied
			ST_FIN:  load_out      = !out_valid_q || report.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- encoder unwrap ----------------
	logic [31:0]        last_pos_q;
	logic [15:0]        enc_adj;
	logic [15:0]        enc_low;
	logic [DELTA_W-1:0] delta_abs;
	logic [31:0]        pos_next;

	assign enc_adj   = count_reverse_q ? (16'd0 - tick.encoder_count) : tick.encoder_count;
	// signed 16-bit step since the last tick
	assign enc_low   = enc_adj - last_pos_q[15:0];
	assign delta_abs = enc_low[15] ? (16'd0 - enc_low) : enc_low;
	assign pos_next  = last_pos_q + {{16{enc_low[15]}}, enc_low};

	// ---------------- command gate ----------------
	logic [8:0] motor_v, drive_v;
	logic       motor_ok, drive_ok;
	logic [8:0] mid_sum;

	always_comb begin
		motor_v = {1'b0, tick.motor_cmd};
		drive_v = {1'b0, tick.drive_cmd};
		// range mode: offset a nonzero command by its minimum
		if (range_only_q && tick.motor_cmd != 8'd0) begin
			motor_v = motor_v + {1'b0, min_motor_q};
		end
		if (range_only_q && tick.drive_cmd != 8'd0) begin
			drive_v = drive_v + {1'b0, min_drive_q};
		end
	end

	assign motor_ok = motor_v >= {1'b0, min_motor_q} && motor_v <= {1'b0, max_motor_q};
	assign drive_ok = drive_v >= {1'b0, min_drive_q} && drive_v <= {1'b0, max_drive_q};
	assign mid_sum  = {1'b0, max_motor_q} + {1'b0, min_motor_q};

	// ---------------- obstacle hysteresis ----------------
	logic [11:0]          sample_w [2];
	logic [NUM_STOPS-1:0] flags_q;
	logic [NUM_STOPS-1:0] flags_d;
	logic [NUM_STOPS-1:0] new_stop;
	logic                 stop;

	assign sample_w[0] = tick.stop_sample_a;
	assign sample_w[1] = tick.stop_sample_b;

	for (genvar i = 0; i < NUM_STOPS; i++) begin : g_stop
		logic at_level, below_clear;
		assign at_level    = sample_w[i] >= obstacle_level_q;
		assign below_clear = sample_w[i] < clear_level_q;
		// a set and a clear may land on the same tick; the stop still counts
		assign new_stop[i] = at_level && !flags_q[i];
		assign flags_d[i]  = (flags_q[i] || at_level) && !below_clear;
	end

	assign stop = |new_stop;

	// ---------------- tick state ----------------
	logic [31:0] pkt_cnt_q;
	logic [7:0]  motor_latch_q, drive_latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_cnt_q     <= '0;
			last_pos_q    <= '0;
			flags_q       <= '0;
			motor_latch_q <= '0;
			drive_latch_q <= '0;
		end else if (tick_fire) begin
			pkt_cnt_q  <= pkt_cnt_q + 32'd1;
			last_pos_q <= pos_next;
			flags_q    <= flags_d;
			// a fresh detection overrides the command with the midpoint
			if (stop) begin
				motor_latch_q <= mid_sum[8:1];
			end else if (motor_ok) begin
				motor_latch_q <= motor_v[7:0];
			end
			if (drive_ok) begin
				drive_latch_q <= drive_v[7:0];
			end
		end
	end

	// ---------------- per-beat hold ----------------
	logic [31:0]           pkt_num_q, ts_q, elapsed_q;
	logic [7:0]            motor_echo_q, drive_echo_q;
	logic [DELTA_W-1:0]    delta_abs_q;
	logic                  negative_q;
	logic [DIVIDEND_W-1:0] product_q;
	logic [DIVIDEND_W-1:0] quotient;
	logic [DELTA_W+SCALE_W-1:0] product_full;

	assign product_full = delta_abs_q * US_PER_SECOND;

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			pkt_num_q      <= pkt_cnt_q;
			ts_q           <= tick.timestamp;
			elapsed_q      <= tick.elapsed_us;
			zero_elapsed_q <= tick.elapsed_us == 32'd0;
			motor_echo_q   <= tick.motor_cmd;
			drive_echo_q   <= tick.drive_cmd;
			delta_abs_q    <= delta_abs;
			negative_q     <= enc_low[15];
		end
		if (state_q == ST_MUL) begin
			product_q <= product_full[DIVIDEND_W-1:0];
		end
	end

	dcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (product_q),
		.divisor  (elapsed_q),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// ---------------- report register ----------------
	logic [SPEED_W-1:0] speed_mag;
	logic [SPEED_W-1:0] speed_val;

	assign speed_mag = zero_elapsed_q ? '0 : {1'b0, quotient};
	assign speed_val = negative_q ? (SPEED_W'(0) - speed_mag) : speed_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			report.packet_number  <= pkt_num_q;
			report.timestamp_echo <= ts_q;
			report.motor_echo     <= motor_echo_q;
			report.drive_echo     <= drive_echo_q;
			report.position       <= last_pos_q;
			report.speed          <= speed_val;
			report.pwm_motor      <= motor_latch_q;
			report.pwm_drive      <= drive_latch_q;
		end
	end

	assign report.valid = out_valid_q;

	// ---------------- checks ----------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> !tick.ready)
		else $error("tick accepted while a beat is in flight");

	a_count_advance: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> pkt_cnt_q == $past(pkt_cnt_q) + 32'd1)
		else $error("packet counter did not advance by one");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_sts.busy)
		else $error("divide state without a running divider");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

endmodule

// ===== tb/drive_report_checker.sv =====
`timescale 1ns / 1ps

// Watches the tick, report and register-write traffic, keeps its own copy of the
// gate state and compares every report beat against the oldest prediction.
module drive_report_checker import dcg_pkg::*; #(
	parameter int NUM_STOPS = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	dcg_tick_if                    tick,
	dcg_report_if                  report,
	output int                     mismatches,
	output int                     reports_due,
	output int                     ticks_seen,
	output int                     reports_seen,
	output int                     stops_seen
);

	typedef struct packed {
		logic [31:0]         packet_number;
		logic [31:0]         timestamp_echo;
		logic [7:0]          motor_echo;
		logic [7:0]          drive_echo;
		logic [31:0]         position;
		logic signed [35:0]  speed;
		logic [7:0]          pwm_motor;
		logic [7:0]          pwm_drive;
	} report_t;

	// register copies
	logic [7:0]  lim_motor_hi, lim_motor_lo, lim_drive_hi, lim_drive_lo;
	logic [11:0] set_level, release_level;
	logic        offset_mode, reverse_count;

	// gate state
	logic        stop_flag [NUM_STOPS];
	logic [31:0] pos_track;
	logic [31:0] next_packet;
	logic [7:0]  held_motor, held_drive;

	report_t expected_reports [$];

	function automatic report_t predict_report(input logic [31:0] ts, el,
			input logic [7:0] m, d, input logic [15:0] enc, input logic [11:0] sa, sb);
		report_t     r;
		logic [15:0] adj, low;
		logic [16:0] mag;
		logic [63:0] quot;
		logic [8:0]  mv, dv, mid;
		logic [11:0] level;
		logic        stop_now;
		stop_now          = 1'b0;
		r.packet_number   = next_packet;
		r.timestamp_echo  = ts;
		r.motor_echo      = m;
		r.drive_echo      = d;
		next_packet       = next_packet + 32'd1;

		// unwrap through a signed 16-bit step
		adj       = reverse_count ? 16'd0 - enc : enc;
		low       = adj - pos_track[15:0];
		mag       = low[15] ? 17'h10000 - {1'b0, low} : {1'b0, low};
		pos_track = low[15] ? pos_track - 32'(mag) : pos_track + 32'(mag);
		r.position = pos_track;
		if (el == 32'd0) begin
			quot = '0;
		end else begin
			quot = (64'(mag) * 64'd1000000) / 64'(el);
			if (low[15])
				quot = 64'd0 - quot;
		end
		r.speed = quot[35:0];

		mv = {1'b0, m};
		dv = {1'b0, d};
		if (offset_mode && m != 8'd0)
			mv = mv + {1'b0, lim_motor_lo};
		if (offset_mode && d != 8'd0)
			dv = dv + {1'b0, lim_drive_lo};

		for (int i = 0; i < NUM_STOPS; i++) begin
			level = (i == 0) ? sa : sb;
			if (level >= set_level && !stop_flag[i]) begin
				stop_flag[i] = 1'b1;
				stop_now     = 1'b1;
			end
			if (level < release_level && stop_flag[i])
				stop_flag[i] = 1'b0;
		end

		if (mv >= {1'b0, lim_motor_lo} && mv <= {1'b0, lim_motor_hi})
			held_motor = mv[7:0];
		if (dv >= {1'b0, lim_drive_lo} && dv <= {1'b0, lim_drive_hi})
			held_drive = dv[7:0];
		if (stop_now) begin
			mid        = ({1'b0, lim_motor_hi} + {1'b0, lim_motor_lo}) >> 1;
			held_motor = mid[7:0];
			stops_seen++;
		end
		r.pwm_motor = held_motor;
		r.pwm_drive = held_drive;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] want, got);
		if (want !== got) begin
			$error("report %s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			// register reset values
			lim_motor_hi  = 8'd20;
			lim_motor_lo  = 8'd10;
			lim_drive_hi  = 8'd17;
			lim_drive_lo  = 8'd7;
			set_level     = 12'd2000;
			release_level = 12'd5;
			offset_mode   = 1'b0;
			reverse_count = 1'b0;
			for (int i = 0; i < NUM_STOPS; i++)
				stop_flag[i] = 1'b0;
			pos_track     = '0;
			next_packet   = '0;
			held_motor    = '0;
			held_drive    = '0;
			expected_reports.delete();
			mismatches    = 0;
			ticks_seen    = 0;
			reports_seen  = 0;
			stops_seen    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_MOTOR:      lim_motor_hi  = cfg_data[7:0];
					REG_MIN_MOTOR:      lim_motor_lo  = cfg_data[7:0];
					REG_MAX_DRIVE:      lim_drive_hi  = cfg_data[7:0];
					REG_MIN_DRIVE:      lim_drive_lo  = cfg_data[7:0];
					REG_OBSTACLE_LEVEL: set_level     = cfg_data;
					REG_CLEAR_LEVEL:    release_level = cfg_data;
					REG_RANGE_ONLY:     offset_mode   = cfg_data[0];
					REG_COUNT_REVERSE:  reverse_count = cfg_data[0];
					default: ;
				endcase
			end
			if (report.valid && report.ready) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					$error("report beat with no tick waiting for it");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					compare_field("packet_number", 64'(want.packet_number),
						64'(report.packet_number));
					compare_field("timestamp_echo", 64'(want.timestamp_echo),
						64'(report.timestamp_echo));
					compare_field("motor_echo", 64'(want.motor_echo),
						64'(report.motor_echo));
					compare_field("drive_echo", 64'(want.drive_echo),
						64'(report.drive_echo));
					compare_field("position", 64'(want.position), 64'(report.position));
					compare_field("speed", {28'd0, want.speed}, {28'd0, report.speed});
					compare_field("pwm_motor", 64'(want.pwm_motor), 64'(report.pwm_motor));
					compare_field("pwm_drive", 64'(want.pwm_drive), 64'(report.pwm_drive));
				end
			end
			if (tick.valid && tick.ready) begin
				ticks_seen++;
				expected_reports.push_back(predict_report(tick.timestamp, tick.elapsed_us,
					tick.motor_cmd, tick.drive_cmd, tick.encoder_count,
					tick.stop_sample_a, tick.stop_sample_b));
			end
		end
		reports_due = expected_reports.size();
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Top of the drive gate bench: makes the clock, reset, register writes and tick
// beats, paces the report side, and gives the verdict. All prediction and
// comparison lives in drive_report_checker.
module testbench;
	import dcg_pkg::*;

	// longest run of cycles with no beat on either channel before giving up;
	// it allows for a whole tick beat plus the long receiver hold-off below
	localparam int IDLE_LIMIT      = 5000;
	localparam int LONG_HOLD       = 400;
	localparam int RANDOM_PHASES   = 6;
	localparam int TICKS_PER_PHASE = 190;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	dcg_tick_if   tick();
	dcg_report_if report();

	int mismatches, reports_due, ticks_seen, reports_seen, stops_seen;

	// pacing knobs, in percent of cycles spent idle
	int send_idle_pct;
	int take_idle_pct;
	bit long_hold_req;
	bit long_hold_done;
	int quiet_cycles;
	int settings_used;

	// shadow of the register values last written, used to aim the stimulus
	logic [7:0]  motor_hi, motor_lo, drive_hi, drive_lo;
	logic [11:0] set_shadow, clr_shadow;
	logic        offset_on;
	logic [15:0] enc_prev;

	drive_command_gate_obstacle_stop dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick),
		.report    (report)
	);

	drive_report_checker report_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick         (tick),
		.report       (report),
		.mismatches   (mismatches),
		.reports_due  (reports_due),
		.ticks_seen   (ticks_seen),
		.reports_seen (reports_seen),
		.stops_seen   (stops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Report side: drop ready at random, and once on request hold it low for a
	// long stretch so the report register fills and the block stops taking ticks.
	initial begin : report_pacer
		report.ready   = 1'b0;
		long_hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				report.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			report.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Count cycles in which no beat moves; end the run when the block hangs.
	initial begin : hang_guard
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((tick.valid && tick.ready) || (report.valid && report.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("no beat for %0d cycles, %0d reports outstanding", IDLE_LIMIT, reports_due);
		$display("*** FAILED ***");
		$finish;
	end

	// One register write per falling edge; the caller lowers the enable afterward.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	// Write all eight registers back to back. Call only with nothing in flight.
	task automatic apply_config(input logic [7:0] mhi, mlo, dhi, dlo,
			input logic [11:0] set_l, clr_l, input logic offs, rev);
		motor_hi   = mhi;
		motor_lo   = mlo;
		drive_hi   = dhi;
		drive_lo   = dlo;
		set_shadow = set_l;
		clr_shadow = clr_l;
		offset_on  = offs;
		settings_used++;
		write_reg(REG_MAX_MOTOR, 12'(mhi));
		write_reg(REG_MIN_MOTOR, 12'(mlo));
		write_reg(REG_MAX_DRIVE, 12'(dhi));
		write_reg(REG_MIN_DRIVE, 12'(dlo));
		write_reg(REG_OBSTACLE_LEVEL, set_l);
		write_reg(REG_CLEAR_LEVEL, clr_l);
		write_reg(REG_RANGE_ONLY, 12'(offs));
		write_reg(REG_COUNT_REVERSE, 12'(rev));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_random_config();
		logic [7:0]  ml, dl;
		logic [11:0] ob;
		ml = 8'($urandom_range(200));
		dl = 8'($urandom_range(200));
		ob = 12'($urandom_range(4095));
		// mostly a sane hysteresis band, sometimes clear above set
		apply_config(8'($urandom_range(255, ml)), ml, 8'($urandom_range(255, dl)), dl, ob,
			($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(ob)),
			1'($urandom), 1'($urandom));
	endtask

	// Present one tick beat, idling first at the sender's rate, and hold it until
	// taken. Returns on the falling edge after acceptance with valid still high.
	task automatic offer_tick(input logic [31:0] ts, el, input logic [7:0] m, d,
			input logic [15:0] enc, input logic [11:0] sa, sb);
		while ($urandom_range(99) < send_idle_pct) begin
			tick.valid <= 1'b0;
			@(negedge clk);
		end
		tick.valid         <= 1'b1;
		tick.timestamp     <= ts;
		tick.elapsed_us    <= el;
		tick.motor_cmd     <= m;
		tick.drive_cmd     <= d;
		tick.encoder_count <= enc;
		tick.stop_sample_a <= sa;
		tick.stop_sample_b <= sb;
		enc_prev = enc;
		do
			@(posedge clk);
		while (!tick.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted report has come back.
	task automatic drain_reports();
		tick.valid <= 1'b0;
		@(negedge clk);
		while (reports_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Commands mostly aimed at the accepted window, taking the offset into account.
	function automatic logic [7:0] pick_command(input logic [7:0] lo, hi);
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'($urandom_range(255));
			default: begin
				if (!offset_on)
					return 8'($urandom_range(lo, hi));
				if (hi < lo)
					return 8'($urandom_range(1, 3));
				return 8'($urandom_range(int'(hi) - int'(lo) + 1));
			end
		endcase
	endfunction

	// Sensor levels: anywhere, in the clear band, or at/above the obstacle level.
	function automatic logic [11:0] pick_level();
		case ($urandom_range(2))
			0: return 12'($urandom_range(4095));
			1: return 12'($urandom_range(int'(clr_shadow)));
			default: return 12'($urandom_range(4095, int'(set_shadow)));
		endcase
	endfunction

	initial begin : stimulus
		logic [31:0] el;
		logic [15:0] enc;

		// every input known from time zero
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		tick.valid         = 1'b0;
		tick.timestamp     = '0;
		tick.elapsed_us    = '0;
		tick.motor_cmd     = '0;
		tick.drive_cmd     = '0;
		tick.encoder_count = '0;
		tick.stop_sample_a = '0;
		tick.stop_sample_b = '0;
		long_hold_req      = 1'b0;
		settings_used      = 0;
		enc_prev           = '0;
		send_idle_pct      = 14;
		take_idle_pct      = 62;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset-like gate window, boundaries of commands and levels,
		// widest encoder steps both ways, zero and extreme elapsed times.
		apply_config(8'd20, 8'd10, 8'd17, 8'd7, 12'd2000, 12'd5, 1'b0, 1'b0);
		offer_tick(32'd0, 32'd0, 8'd0, 8'd0, 16'h0000, 12'd0, 12'd0);
		offer_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd10, 8'd17, 16'h7FFF, 12'd4095, 12'd0);
		// largest negative step wraps position below zero
		offer_tick(32'd1, 32'd1, 8'd20, 8'd7, 16'hFFFF, 12'd4095, 12'd4095);
		// largest positive step at one microsecond: top speed
		offer_tick(32'd2, 32'd1, 8'd21, 8'd6, 16'h7FFE, 12'd0, 12'd4095);
		offer_tick(32'd3, 32'd1000, 8'd9, 8'd18, 16'h7F00, 12'd1999, 12'd4);
		offer_tick(32'd4, 32'd1000, 8'd255, 8'd255, 16'h7F40, 12'd2000, 12'd5);
		offer_tick(32'd5, 32'd1000000, 8'd15, 8'd12, 16'h7E00, 12'd5, 12'd2000);
		drain_reports();

		// full window, offset mode with zero minimum, reversed encoder
		apply_config(8'd255, 8'd0, 8'd255, 8'd0, 12'd4095, 12'd0, 1'b1, 1'b1);
		offer_tick($urandom, 32'd7, 8'd0, 8'd0, 16'h0001, 12'd4095, 12'd4095);
		offer_tick($urandom, 32'd3, 8'd255, 8'd255, 16'h8000, 12'd0, 12'd4094);
		offer_tick($urandom, 32'd250, 8'd128, 8'd1, 16'hFF00, 12'd4095, 12'd0);
		drain_reports();

		// clear level above obstacle level: set and clear on one tick;
		// large minimum pushes offset commands past 255
		apply_config(8'd250, 8'd200, 8'd255, 8'd128, 12'd100, 12'd3000, 1'b1, 1'b0);
		offer_tick($urandom, 32'd500, 8'd60, 8'd127, 16'h1234, 12'd50, 12'd50);
		offer_tick($urandom, 32'd500, 8'd50, 8'd1, 16'h1200, 12'd100, 12'd99);
		offer_tick($urandom, 32'd500, 8'd0, 8'd0, 16'h1300, 12'd4000, 12'd2999);
		offer_tick($urandom, 32'd0, 8'd56, 8'd128, 16'hF000, 12'd3000, 12'd100);
		offer_tick($urandom, 32'd2, 8'd55, 8'd200, 16'hF001, 12'd2999, 12'd3000);
		drain_reports();

		// Random phases: first sender light / receiver heavy idling, then the
		// reverse, then none, with the long receiver hold-off in the last group.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: apply_config(8'd20, 8'd10, 8'd17, 8'd7, 12'd2000, 12'd5, 1'b0, 1'b0);
				// empty windows, always set and nearly always clear
				3: apply_config(8'd0, 8'd255, 8'd0, 8'd255, 12'd0, 12'd4095, 1'b1, 1'b1);
				4: apply_config(8'd255, 8'd0, 8'd255, 8'd0, 12'd4095, 12'd0, 1'b0, 1'b0);
				default: apply_random_config();
			endcase
			send_idle_pct = (p < 2) ? 14 : (p < 4) ? 62 : 0;
			take_idle_pct = (p < 2) ? 62 : (p < 4) ? 14 : 0;
			if (p == 4)
				long_hold_req = 1'b1;
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				case ($urandom_range(9))
					0: el = 32'd0;
					1: el = $urandom;
					2: el = $urandom_range(1, 3);
					default: el = $urandom_range(500, 20000);
				endcase
				// mostly a wheel turning slowly, now and then a jump anywhere
				if ($urandom_range(9) == 0)
					enc = 16'($urandom);
				else
					enc = enc_prev + 16'($urandom_range(600)) - 16'd300;
				offer_tick($urandom, el, pick_command(motor_lo, motor_hi),
					pick_command(drive_lo, drive_hi), enc, pick_level(), pick_level());
			end
			drain_reports();
		end

		// let any late beat show up before judging
		repeat (48) @(negedge clk);

		$display("Ran %0d ticks and %0d reports across %0d register settings, %0d obstacle stops.",
			ticks_seen, reports_seen, settings_used, stops_seen);
		$display("Idling covered both sides, a long report hold-off and back-to-back beats.");
		if (mismatches == 0 && reports_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
sv/dcg_pkg.sv
sv/dcg_tick_if.sv
sv/dcg_report_if.sv
sv/dcg_div.sv
sv/drive_command_gate_obstacle_stop.sv
tb/drive_report_checker.sv
tb/testbench.sv
